/* src/lgft_pkg.sv */
`timescale 1ns / 1ps
// lgft_pkg: shared widths, gait tables and unit request/response types
// used by the serial multiplier, the serial divider and the top level

package lgft_pkg;

	localparam int NUM_GAITS = 5;
	localparam int NUM_LEGS  = 6;

	// operand width of the serial units, product/dividend width, divisor width
	localparam int MW = 11;
	localparam int PW = 2 * MW;
	localparam int DW = 11;

	// lift window in hundredths of a step, its middle, percent scale
	localparam int LIFT_SPAN_H = 400;
	localparam int LIFT_MID_H  = 200;
	localparam int PCT_SCALE   = 100;
	localparam int STEP_H      = 100;

	localparam logic [4:0] CYC_STEPS [NUM_GAITS] = '{5'd12, 5'd12, 5'd16, 5'd24, 5'd12};
	localparam logic [11:0] CYC_H [NUM_GAITS] =
		'{12'd1200, 12'd1200, 12'd1600, 12'd2400, 12'd1200};
	localparam logic [10:0] GDIV_H [NUM_GAITS] =
		'{11'd800, 11'd800, 11'd1200, 11'd2000, 11'd800};
	// lift window plus half the ground window
	localparam logic [11:0] GMID_H [NUM_GAITS] =
		'{12'd800, 12'd800, 12'd1000, 12'd1400, 12'd800};
	localparam logic [11:0] OFF_H [NUM_GAITS][NUM_LEGS] = '{
		'{12'd100, 12'd300, 12'd500, 12'd700, 12'd900, 12'd1100},
		'{12'd0, 12'd600, 12'd0, 12'd600, 12'd0, 12'd600},
		'{12'd0, 12'd800, 12'd0, 12'd800, 12'd0, 12'd800},
		'{12'd0, 12'd400, 12'd800, 12'd1200, 12'd1600, 12'd2000},
		'{12'd0, 12'd600, 12'd0, 12'd600, 12'd0, 12'd600}
	};

	typedef struct packed {
		logic          start;
		logic [MW-1:0] a;
		logic [MW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic          done;
		logic [PW-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic          start;
		logic [PW-1:0] num;
		logic [DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [PW-1:0] quo;
	} div_rsp_t;

	function automatic logic [2:0] gait_idx(input logic [2:0] sel);
		return (sel < 3'(NUM_GAITS)) ? sel : 3'd0;
	endfunction

	function automatic logic [4:0] gait_steps(input logic [2:0] sel);
		return CYC_STEPS[gait_idx(sel)];
	endfunction

	function automatic logic [11:0] gait_cyc_h(input logic [2:0] sel);
		return CYC_H[gait_idx(sel)];
	endfunction

	function automatic logic [10:0] gait_gdiv_h(input logic [2:0] sel);
		return GDIV_H[gait_idx(sel)];
	endfunction

	function automatic logic [11:0] gait_gmid_h(input logic [2:0] sel);
		return GMID_H[gait_idx(sel)];
	endfunction

	function automatic logic [11:0] gait_off_h(input logic [2:0] sel, input logic [2:0] leg);
		logic [2:0] l;
		l = (leg < 3'(NUM_LEGS)) ? leg : 3'd0;
		return OFF_H[gait_idx(sel)][l];
	endfunction

endpackage

/* src/legged_gait_foot_trajectory_core.sv */
`timescale 1ns / 1ps
// Foot trajectory generator for a six-legged gait: an advance item steps the gait
// counter and its result passes through the finish state into the output register.
// A compute item steps through the setup states PH0, PH1 and PH2 for the leg phase,
// then runs multiply-then-divide operations on a shared bit-serial multiplier and
// restoring divider: four operations in the lifting phase, two on the ground. One
// item is in work at a time; the finished item waits in the output register while
// the next one is accepted, and a result that is still waiting there holds the next
// one back until it leaves.
// Depends on lgft_pkg, lgft_mul and lgft_div.

module legged_gait_foot_trajectory_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [2:0]         leg,
	input  logic [6:0]         sub_phase,
	input  logic signed [10:0] stride_x,
	input  logic signed [10:0] stride_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [10:0] pos_x,
	output logic signed [8:0]  pos_y,
	output logic signed [10:0] pos_z,
	output logic [7:0]         lift,
	output logic               foot_lifting,
	output logic [4:0]         step_now,
	output logic [11:0]        cycle_phase
);

	localparam int MW = lgft_pkg::MW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PH0  = 3'd1;
	localparam logic [2:0] S_PH1  = 3'd2;
	localparam logic [2:0] S_PH2  = 3'd3;
	localparam logic [2:0] S_GO   = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	localparam logic [1:0] OP_PCT  = 2'd0;
	localparam logic [1:0] OP_LIFT = 2'd1;
	localparam logic [1:0] OP_X    = 2'd2;
	localparam logic [1:0] OP_Z    = 2'd3;

	localparam logic       REG_GAIT = 1'b0;
	localparam logic       REG_LHM  = 1'b1;

	logic [2:0]  state_q;
	logic [1:0]  op_q;
	logic [2:0]  gait_q;
	logic [7:0]  lhm_q;
	logic [4:0]  step_q;
	logic        out_valid_q;

	logic [2:0]  leg_q;
	logic [6:0]  sub_q;
	logic [10:0] tx_q;
	logic [10:0] tz_q;
	logic [12:0] raw_q;
	logic [11:0] phase_q;
	logic        lifting_q;
	logic        csign_q;
	logic [10:0] cmag_q;
	logic [10:0] den_q;
	logic [6:0]  pct_q;
	logic [7:0]  lift_q;
	logic [10:0] resx_q;
	logic [10:0] resz_q;

	logic [10:0] pos_x_q;
	logic [8:0]  pos_y_q;
	logic [10:0] pos_z_q;
	logic [7:0]  lift_o_q;
	logic        foot_lifting_q;
	logic [4:0]  step_now_q;
	logic [11:0] cycle_phase_q;

	logic        accept;
	logic        out_free;
	logic        out_load;
	logic [4:0]  step_nxt;
	logic [11:0] step_h;
	logic [12:0] raw;
	logic [12:0] cyc13;
	logic [12:0] wrapped;
	logic        lift_win;
	logic [12:0] ctr;
	logic [12:0] ctr_mag;
	logic [10:0] magx;
	logic [10:0] magz;
	logic [MW-1:0] qv;
	logic        negq;

	lgft_pkg::mul_req_t mul_req;
	lgft_pkg::mul_rsp_t mul_rsp;
	lgft_pkg::div_req_t div_req;
	lgft_pkg::div_rsp_t div_rsp;

	lgft_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	lgft_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_FIN) && out_free;
	assign step_nxt = step_q + 5'd1;

	// leg phase in hundredths, wrapped into one cycle
	assign step_h  = {7'd0, step_q} * 12'(lgft_pkg::STEP_H);
	assign raw     = {1'b0, step_h} + {6'd0, sub_q}
		- {1'b0, lgft_pkg::gait_off_h(gait_q, leg_q)};
	assign cyc13   = {1'b0, lgft_pkg::gait_cyc_h(gait_q)};
	assign wrapped = raw_q[12] ? (raw_q + cyc13)
		: ((raw_q >= cyc13) ? (raw_q - cyc13) : raw_q);

	// sweep position relative to the middle of the current window
	assign lift_win = (phase_q < 12'(lgft_pkg::LIFT_SPAN_H));
	assign ctr      = {1'b0, phase_q}
		- {1'b0, lift_win ? 12'(lgft_pkg::LIFT_MID_H) : lgft_pkg::gait_gmid_h(gait_q)};
	assign ctr_mag  = ctr[12] ? (13'd0 - ctr) : ctr;

	assign magx = tx_q[10] ? (11'd0 - tx_q) : tx_q;
	assign magz = tz_q[10] ? (11'd0 - tz_q) : tz_q;

	always_comb begin
		mul_req.start = (state_q == S_GO);
		div_req.start = (state_q == S_MUL) && mul_rsp.done;
		div_req.num   = mul_rsp.prod;
		case (op_q)
			OP_PCT: begin
				mul_req.a   = {2'b00, phase_q[8:0]};
				mul_req.b   = 11'(lgft_pkg::LIFT_SPAN_H) - {2'b00, phase_q[8:0]};
				div_req.den = 11'(lgft_pkg::LIFT_SPAN_H);
			end
			OP_LIFT: begin
				mul_req.a   = {3'b000, lhm_q};
				mul_req.b   = {4'b0000, pct_q};
				div_req.den = 11'(lgft_pkg::PCT_SCALE);
			end
			OP_X: begin
				mul_req.a   = magx;
				mul_req.b   = cmag_q;
				div_req.den = den_q;
			end
			default: begin
				mul_req.a   = magz;
				mul_req.b   = cmag_q;
				div_req.den = den_q;
			end
		endcase
	end

	// quotient sign: travel sign times sweep sign, flipped on the ground
	assign qv   = div_rsp.quo[MW-1:0];
	assign negq = ((op_q == OP_X) ? tx_q[10] : tz_q[10]) ^ csign_q ^ !lifting_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_PCT;
			gait_q      <= '0;
			lhm_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIT: begin
						gait_q <= cfg_data[2:0];
						step_q <= '0;
					end
					REG_LHM: begin
						lhm_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!action) begin
							step_q  <= (step_nxt >= lgft_pkg::gait_steps(gait_q)) ?
								5'd0 : step_nxt;
							state_q <= S_FIN;
						end else begin
							state_q <= S_PH0;
						end
					end
				end
				S_PH0: state_q <= S_PH1;
				S_PH1: state_q <= S_PH2;
				S_PH2: begin
					op_q    <= lift_win ? OP_PCT : OP_X;
					state_q <= S_GO;
				end
				S_GO: state_q <= S_MUL;
				S_MUL: begin
					if (mul_rsp.done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (op_q == OP_Z) begin
							state_q <= S_FIN;
						end else begin
							op_q    <= op_q + 2'd1;
							state_q <= S_GO;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					leg_q     <= leg;
					sub_q     <= sub_phase;
					tx_q      <= stride_x;
					tz_q      <= stride_z;
					phase_q   <= '0;
					lifting_q <= 1'b0;
					lift_q    <= '0;
					resx_q    <= '0;
					resz_q    <= '0;
				end
			end
			S_PH0: raw_q <= raw;
			S_PH1: phase_q <= wrapped[11:0];
			S_PH2: begin
				lifting_q <= lift_win;
				csign_q   <= ctr[12];
				cmag_q    <= ctr_mag[10:0];
				den_q     <= lift_win ? 11'(lgft_pkg::LIFT_SPAN_H) : lgft_pkg::gait_gdiv_h(gait_q);
			end
			S_DIV: begin
				if (div_rsp.done) begin
					case (op_q)
						OP_PCT:  pct_q  <= qv[6:0];
						OP_LIFT: lift_q <= qv[7:0];
						OP_X:    resx_q <= negq ? (11'd0 - qv) : qv;
						default: resz_q <= negq ? (11'd0 - qv) : qv;
					endcase
				end
			end
			S_FIN: begin
				if (out_free) begin
					pos_x_q        <= resx_q;
					pos_y_q        <= 9'd0 - {1'b0, lift_q};
					pos_z_q        <= resz_q;
					lift_o_q       <= lift_q;
					foot_lifting_q <= lifting_q;
					step_now_q     <= step_q;
					cycle_phase_q  <= phase_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign lift         = lift_o_q;
	assign foot_lifting = foot_lifting_q;
	assign step_now     = step_now_q;
	assign cycle_phase  = cycle_phase_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted while another is in work");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < lgft_pkg::gait_steps(gait_q))
		else $error("gait step counter beyond cycle length");

	a_pos_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_y == (9'd0 - {1'b0, lift})))
		else $error("pos_y does not match lift");

	a_ground_lift: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !foot_lifting) |-> (lift == 8'd0))
		else $error("nonzero lift on the ground");

endmodule

/* src/lgft_mul.sv */
`timescale 1ns / 1ps
// lgft_mul: unsigned shift-add multiplier, one multiplier bit per cycle
// depends on lgft_pkg for widths and request/response types

module lgft_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  lgft_pkg::mul_req_t  req,
	output lgft_pkg::mul_rsp_t  rsp
);

	localparam int MW  = lgft_pkg::MW;
	localparam int PW  = lgft_pkg::PW;
	localparam int MCW = $clog2(MW + 1);

	logic           busy_q;
	logic           done_q;
	logic [MCW-1:0] cnt_q;
	logic [MW-1:0]  a_q;
	logic [PW-1:0]  prod_q;
	logic [MW:0]    sum;

	// add the multiplicand into the upper half when the low bit is set
	assign sum = {1'b0, prod_q[PW-1:MW]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == MCW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= MCW'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MCW'(1);
				if (cnt_q == MCW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a;
			prod_q <= {{MW{1'b0}}, req.b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[MW-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule

/* src/lgft_div.sv */
`timescale 1ns / 1ps
// lgft_div: unsigned restoring divider, one quotient bit per cycle
// depends on lgft_pkg for widths and request/response types

module lgft_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lgft_pkg::div_req_t  req,
	output lgft_pkg::div_rsp_t  rsp
);

	localparam int PW  = lgft_pkg::PW;
	localparam int DW  = lgft_pkg::DW;
	localparam int DCW = $clog2(PW + 1);

	logic           busy_q;
	logic           done_q;
	logic [DCW-1:0] cnt_q;
	logic [DW-1:0]  den_q;
	logic [DW-1:0]  rem_q;
	logic [PW-1:0]  num_q;
	logic [DW+1:0]  diff;
	logic           borrow;

	// trial subtract of the divisor from the shifted remainder
	assign diff   = {1'b0, rem_q, num_q[PW-1]} - {2'b00, den_q};
	assign borrow = diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DCW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCW'(1);
				if (cnt_q == DCW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			num_q <= req.num;
		end else if (busy_q) begin
			rem_q <= borrow ? {rem_q[DW-2:0], num_q[PW-1]} : diff[DW-1:0];
			num_q <= {num_q[PW-2:0], ~borrow};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule
